// ----- hdl/pfcv_pkg.sv -----
// pfcv_pkg: shared types, constants and codes for the performance-lock vote table
// depends on nothing; used by every module of the block
`default_nettype none

package pfcv_pkg;

    localparam int NUM_LOCKS_DEF  = 16;
    localparam int NUM_LEVELS_DEF = 4;

    localparam int ACT_W     = 3;
    localparam int ID_W      = 4;
    localparam int LEVEL_W   = 3;
    localparam int STAT_W    = 3;
    localparam int SLEVEL_W  = 2;
    localparam int HZ_W      = 32;
    localparam int KHZ_W     = 22;
    localparam int REG_W     = 64;
    localparam int ADDR_W    = 6;
    localparam int REG_LSB   = 3;
    localparam int REG_IDX_W = 3;
    localparam int ID_SPAN   = 1 << ID_W;
    localparam int KHZ_TO_HZ = 1000;

    localparam logic [KHZ_W-1:0] MAX_KHZ_RST = {KHZ_W{1'b1}};

    localparam logic [ACT_W-1:0] ACT_CREATE     = 3'd0;
    localparam logic [ACT_W-1:0] ACT_ACTIVATE   = 3'd1;
    localparam logic [ACT_W-1:0] ACT_DEACTIVATE = 3'd2;
    localparam logic [ACT_W-1:0] ACT_RELEASE    = 3'd3;
    localparam logic [ACT_W-1:0] ACT_QUERY      = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK          = 3'd0;
    localparam logic [STAT_W-1:0] ST_BAD_LEVEL   = 3'd1;
    localparam logic [STAT_W-1:0] ST_ALREADY     = 3'd2;
    localparam logic [STAT_W-1:0] ST_NOT_CREATED = 3'd3;
    localparam logic [STAT_W-1:0] ST_NOT_READY   = 3'd4;
    localparam logic [STAT_W-1:0] ST_OVER        = 3'd5;
    localparam logic [STAT_W-1:0] ST_UNDER       = 3'd6;
    localparam logic [STAT_W-1:0] ST_NO_LOCK     = 3'd7;

    localparam logic KIND_FLOOR = 1'b0;
    localparam logic KIND_CEIL  = 1'b1;

    localparam logic [REG_IDX_W-1:0] REG_FLOOR_LO   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_FLOOR_HI   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_CEIL_LO    = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_CEIL_HI    = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_MIN_KHZ    = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_MAX_KHZ    = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_FLOOR_RDY  = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_CEIL_RDY   = 3'd7;

    typedef struct packed {
        logic [ACT_W-1:0]   action;
        logic [ID_W-1:0]    lock_id;
        logic               lock_kind;
        logic [LEVEL_W-1:0] vote_level;
    } t_in_beat;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic              lock_active;
        logic              any_floor_active;
        logic [HZ_W-1:0]   floor_hz;
        logic [HZ_W-1:0]   ceiling_hz;
    } t_out_beat;

    typedef struct packed {
        logic [REG_W-1:0] floor_lo;
        logic [REG_W-1:0] floor_hi;
        logic [REG_W-1:0] ceil_lo;
        logic [REG_W-1:0] ceil_hi;
        logic [KHZ_W-1:0] min_khz;
        logic [KHZ_W-1:0] max_khz;
        logic             floor_ready;
        logic             ceil_ready;
    } t_cfg;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_PICK,
        S_DONE
    } t_state;

    typedef struct packed {
        logic capture;
        logic eval;
        logic pick;
        logic load;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_stat;

endpackage

`default_nettype wire

// ----- hdl/pfcv_regs.sv -----
// pfcv_regs: apb-style configuration registers (tables, policy limits, ready flags)
// depends on pfcv_pkg
`default_nettype none

module pfcv_regs (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_psel,
    input  wire logic                          i_penable,
    input  wire logic                          i_pwrite,
    input  wire logic [pfcv_pkg::ADDR_W-1:0]   i_paddr,
    input  wire logic [pfcv_pkg::REG_W-1:0]    i_pwdata,
    output logic      [pfcv_pkg::REG_W-1:0]    o_prdata,
    output pfcv_pkg::t_cfg                     o_cfg
);

    pfcv_pkg::t_cfg                    r_cfg;
    logic [pfcv_pkg::REG_IDX_W-1:0]    reg_idx;
    logic                              wr_en;

    assign reg_idx = i_paddr[pfcv_pkg::ADDR_W-1:pfcv_pkg::REG_LSB];
    assign wr_en   = i_psel && i_penable && i_pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.floor_lo    <= '0;
            r_cfg.floor_hi    <= '0;
            r_cfg.ceil_lo     <= '0;
            r_cfg.ceil_hi     <= '0;
            r_cfg.min_khz     <= '0;
            r_cfg.max_khz     <= pfcv_pkg::MAX_KHZ_RST;
            r_cfg.floor_ready <= 1'b0;
            r_cfg.ceil_ready  <= 1'b0;
        end else if (wr_en) begin
            unique case (reg_idx)
                pfcv_pkg::REG_FLOOR_LO:  r_cfg.floor_lo    <= i_pwdata;
                pfcv_pkg::REG_FLOOR_HI:  r_cfg.floor_hi    <= i_pwdata;
                pfcv_pkg::REG_CEIL_LO:   r_cfg.ceil_lo     <= i_pwdata;
                pfcv_pkg::REG_CEIL_HI:   r_cfg.ceil_hi     <= i_pwdata;
                pfcv_pkg::REG_MIN_KHZ:   r_cfg.min_khz     <= i_pwdata[pfcv_pkg::KHZ_W-1:0];
                pfcv_pkg::REG_MAX_KHZ:   r_cfg.max_khz     <= i_pwdata[pfcv_pkg::KHZ_W-1:0];
                pfcv_pkg::REG_FLOOR_RDY: r_cfg.floor_ready <= i_pwdata[0];
                pfcv_pkg::REG_CEIL_RDY:  r_cfg.ceil_ready  <= i_pwdata[0];
                default:                 r_cfg.ceil_ready  <= r_cfg.ceil_ready;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            pfcv_pkg::REG_FLOOR_LO:  o_prdata = r_cfg.floor_lo;
            pfcv_pkg::REG_FLOOR_HI:  o_prdata = r_cfg.floor_hi;
            pfcv_pkg::REG_CEIL_LO:   o_prdata = r_cfg.ceil_lo;
            pfcv_pkg::REG_CEIL_HI:   o_prdata = r_cfg.ceil_hi;
            pfcv_pkg::REG_MIN_KHZ:   o_prdata = pfcv_pkg::REG_W'(r_cfg.min_khz);
            pfcv_pkg::REG_MAX_KHZ:   o_prdata = pfcv_pkg::REG_W'(r_cfg.max_khz);
            pfcv_pkg::REG_FLOOR_RDY: o_prdata = pfcv_pkg::REG_W'(r_cfg.floor_ready);
            pfcv_pkg::REG_CEIL_RDY:  o_prdata = pfcv_pkg::REG_W'(r_cfg.ceil_ready);
            default:                 o_prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ----- hdl/pfcv_ctrl.sv -----
// pfcv_ctrl: sequencer for one beat (capture, entry update, level pick, result load)
// depends on pfcv_pkg; drives the datapath in pfcv_dp through t_dp_cmd
`default_nettype none

module pfcv_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  pfcv_pkg::t_dp_stat      i_stat,
    output pfcv_pkg::t_dp_cmd       o_cmd,
    output logic                    o_in_stall
);

    pfcv_pkg::t_state r_state;
    pfcv_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pfcv_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            pfcv_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = pfcv_pkg::S_EVAL;
                end
            end
            pfcv_pkg::S_EVAL: begin
                o_cmd.eval = 1'b1;
                n_state    = pfcv_pkg::S_PICK;
            end
            pfcv_pkg::S_PICK: begin
                o_cmd.pick = 1'b1;
                n_state    = pfcv_pkg::S_DONE;
            end
            pfcv_pkg::S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.load = 1'b1;
                    n_state    = pfcv_pkg::S_IDLE;
                end
            end
            default: n_state = pfcv_pkg::S_IDLE;
        endcase
    end

    assign o_in_stall = (r_state != pfcv_pkg::S_IDLE);

endmodule

`default_nettype wire

// ----- hdl/pfcv_dp.sv -----
// pfcv_dp: lock entries, per-level active counters, table pick, clamp and result register
// depends on pfcv_pkg; sequenced by pfcv_ctrl, configured from pfcv_regs
`default_nettype none

module pfcv_dp #(
    parameter int NUM_LOCKS  = pfcv_pkg::NUM_LOCKS_DEF,
    parameter int NUM_LEVELS = pfcv_pkg::NUM_LEVELS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  pfcv_pkg::t_dp_cmd       i_cmd,
    input  pfcv_pkg::t_in_beat      i_in_data,
    input  pfcv_pkg::t_cfg          i_cfg,
    input  wire logic               i_out_stall,
    output pfcv_pkg::t_dp_stat      o_stat,
    output logic                    o_out_valid,
    output pfcv_pkg::t_out_beat     o_out_data
);

    localparam int ENTRIES = (NUM_LOCKS < pfcv_pkg::ID_SPAN) ? NUM_LOCKS : pfcv_pkg::ID_SPAN;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int HZ_W    = pfcv_pkg::HZ_W;
    localparam int LV_W    = pfcv_pkg::SLEVEL_W;

    function automatic logic [HZ_W-1:0] table_pick(
        input logic [pfcv_pkg::REG_W-1:0] lo,
        input logic [pfcv_pkg::REG_W-1:0] hi,
        input logic [LV_W-1:0]            lvl
    );
        logic [pfcv_pkg::REG_W-1:0] word;
        word = lvl[1] ? hi : lo;
        return lvl[0] ? word[pfcv_pkg::REG_W-1:HZ_W] : word[HZ_W-1:0];
    endfunction

    function automatic logic [HZ_W-1:0] clamp(
        input logic [HZ_W-1:0] raw,
        input logic [HZ_W-1:0] top,
        input logic [HZ_W-1:0] bot
    );
        logic [HZ_W-1:0] res;
        if (raw > top) begin
            res = top;
        end else if (raw < bot) begin
            res = bot;
        end else begin
            res = raw;
        end
        return res;
    endfunction

    pfcv_pkg::t_in_beat          r_item;
    logic [ENTRIES-1:0]          r_created;
    logic [ENTRIES-1:0]          r_active;
    logic [ENTRIES-1:0]          r_kind;
    logic [LV_W-1:0]             r_level [ENTRIES];
    logic [CNT_W-1:0]            r_cnt [2][NUM_LEVELS];
    logic [HZ_W-1:0]             r_top;
    logic [HZ_W-1:0]             r_bot;
    logic [pfcv_pkg::STAT_W-1:0] r_status;
    logic                        r_lock_active;
    logic                        r_any_floor;
    logic                        r_any_ceil;
    logic [HZ_W-1:0]             r_floor_raw;
    logic [HZ_W-1:0]             r_ceil_raw;
    logic                        r_out_valid;
    pfcv_pkg::t_out_beat         r_out;

    // entry update
    logic                        id_ok;
    logic [IDX_W-1:0]            idx;
    logic                        cur_created;
    logic                        cur_active;
    logic                        cur_kind;
    logic [LV_W-1:0]             cur_level;
    logic                        ready;
    logic                        wr_en;
    logic                        new_created;
    logic                        new_active;
    logic                        new_kind;
    logic [LV_W-1:0]             new_level;
    logic                        cnt_inc;
    logic                        cnt_dec;
    logic [pfcv_pkg::STAT_W-1:0] n_status;

    // level pick
    logic                        any_floor;
    logic                        any_ceil;
    logic [LV_W-1:0]             fmax;
    logic [LV_W-1:0]             cmin;

    logic                        out_free;

    assign id_ok       = (int'(r_item.lock_id) < NUM_LOCKS);
    assign idx         = r_item.lock_id[IDX_W-1:0];
    assign cur_created = r_created[idx];
    assign cur_active  = r_active[idx];
    assign cur_kind    = r_kind[idx];
    assign cur_level   = r_level[idx];
    assign ready       = (cur_kind == pfcv_pkg::KIND_CEIL) ? i_cfg.ceil_ready
                                                           : i_cfg.floor_ready;

    always_comb begin
        n_status    = pfcv_pkg::ST_OK;
        wr_en       = 1'b0;
        new_created = cur_created;
        new_active  = cur_active;
        new_kind    = cur_kind;
        new_level   = cur_level;
        cnt_inc     = 1'b0;
        cnt_dec     = 1'b0;
        if (!id_ok) begin
            n_status = pfcv_pkg::ST_NO_LOCK;
        end else begin
            unique case (r_item.action) inside
                pfcv_pkg::ACT_CREATE: begin
                    if (int'(r_item.vote_level) >= NUM_LEVELS) begin
                        n_status = pfcv_pkg::ST_BAD_LEVEL;
                    end else if (cur_created) begin
                        n_status = pfcv_pkg::ST_ALREADY;
                    end else begin
                        wr_en       = 1'b1;
                        new_created = 1'b1;
                        new_active  = 1'b0;
                        new_kind    = r_item.lock_kind;
                        new_level   = r_item.vote_level[LV_W-1:0];
                    end
                end
                pfcv_pkg::ACT_ACTIVATE, pfcv_pkg::ACT_DEACTIVATE: begin
                    if (!cur_created) begin
                        n_status = pfcv_pkg::ST_NOT_CREATED;
                    end else if (!ready) begin
                        n_status = pfcv_pkg::ST_NOT_READY;
                    end else if (r_item.action == pfcv_pkg::ACT_ACTIVATE && cur_active) begin
                        n_status = pfcv_pkg::ST_OVER;
                    end else if (r_item.action == pfcv_pkg::ACT_DEACTIVATE && !cur_active) begin
                        n_status = pfcv_pkg::ST_UNDER;
                    end else begin
                        wr_en      = 1'b1;
                        new_active = (r_item.action == pfcv_pkg::ACT_ACTIVATE);
                        cnt_inc    = (r_item.action == pfcv_pkg::ACT_ACTIVATE);
                        cnt_dec    = (r_item.action == pfcv_pkg::ACT_DEACTIVATE);
                    end
                end
                pfcv_pkg::ACT_RELEASE: begin
                    if (!cur_created) begin
                        n_status = pfcv_pkg::ST_NO_LOCK;
                    end else begin
                        wr_en       = 1'b1;
                        new_created = 1'b0;
                        new_active  = 1'b0;
                        new_kind    = 1'b0;
                        new_level   = '0;
                        cnt_dec     = cur_active;
                    end
                end
                default: begin
                    n_status = pfcv_pkg::ST_OK;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_created <= '0;
            r_active  <= '0;
            r_kind    <= '0;
            r_level   <= '{default: '0};
        end else if (i_cmd.eval && wr_en) begin
            r_created[idx] <= new_created;
            r_active[idx]  <= new_active;
            r_kind[idx]    <= new_kind;
            r_level[idx]   <= new_level;
        end
    end

    // active locks per kind and level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '{default: '0};
        end else if (i_cmd.eval) begin
            for (int k = 0; k < 2; k++) begin
                for (int l = 0; l < NUM_LEVELS; l++) begin
                    if (cur_kind == 1'(k) && cur_level == LV_W'(l)) begin
                        if (cnt_inc) begin
                            r_cnt[k][l] <= r_cnt[k][l] + CNT_W'(1);
                        end else if (cnt_dec) begin
                            r_cnt[k][l] <= r_cnt[k][l] - CNT_W'(1);
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.eval) begin
            r_status      <= n_status;
            r_lock_active <= id_ok && new_active;
        end
    end

    always_comb begin
        any_floor = 1'b0;
        any_ceil  = 1'b0;
        fmax      = '0;
        cmin      = LV_W'(NUM_LEVELS - 1);
        for (int l = 0; l < NUM_LEVELS; l++) begin
            if (r_cnt[pfcv_pkg::KIND_FLOOR][l] != '0) begin
                any_floor = 1'b1;
                fmax      = LV_W'(l);
            end
        end
        for (int l = NUM_LEVELS - 1; l >= 0; l--) begin
            if (r_cnt[pfcv_pkg::KIND_CEIL][l] != '0) begin
                any_ceil = 1'b1;
                cmin     = LV_W'(l);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.pick) begin
            r_any_floor <= any_floor;
            r_any_ceil  <= any_ceil;
            r_floor_raw <= table_pick(i_cfg.floor_lo, i_cfg.floor_hi, fmax);
            r_ceil_raw  <= table_pick(i_cfg.ceil_lo, i_cfg.ceil_hi, cmin);
        end
    end

    // clamp bounds in hertz
    always_ff @(posedge i_clk) begin
        r_top <= HZ_W'(i_cfg.max_khz) * HZ_W'(pfcv_pkg::KHZ_TO_HZ);
        r_bot <= HZ_W'(i_cfg.min_khz) * HZ_W'(pfcv_pkg::KHZ_TO_HZ);
    end

    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_out.status           <= r_status;
            r_out.lock_active      <= r_lock_active;
            r_out.any_floor_active <= r_any_floor;
            r_out.floor_hz         <= r_any_floor ? clamp(r_floor_raw, r_top, r_bot) : '0;
            r_out.ceiling_hz       <= r_any_ceil ? clamp(r_ceil_raw, r_top, r_bot) : '0;
        end
    end

    assign o_stat.out_free = out_free;
    assign o_out_valid     = r_out_valid;
    assign o_out_data      = r_out;

endmodule

`default_nettype wire

// ----- hdl/perf_floor_ceiling_vote_table.sv -----
// Performance-lock vote table: one beat creates, activates, deactivates or releases a
// lock entry (or only queries) and returns status, the entry's active flag, whether
// any floor lock is active, and the clamped floor and ceiling frequencies. A beat is
// captured at acceptance, and the controller then steps through entry update, level
// pick from the per-level active counters, and clamp and load of the result; a new
// beat is taken only once that load is done. The controller steps in a fixed order over
// the single entry table, and a stalled result holds the block in its last step.
// No clearing pass is needed after reset. Configuration registers are 64 bits wide
// at byte address 8*i; write them only while no beat is in flight.
`default_nettype none

module perf_floor_ceiling_vote_table #(
    parameter int NUM_LOCKS  = pfcv_pkg::NUM_LOCKS_DEF,
    parameter int NUM_LEVELS = pfcv_pkg::NUM_LEVELS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  pfcv_pkg::t_in_beat                 i_in_data,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output pfcv_pkg::t_out_beat                o_out_data,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [pfcv_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [pfcv_pkg::REG_W-1:0]    pwdata,
    output logic      [pfcv_pkg::REG_W-1:0]    prdata,
    output logic                               pready
);

    pfcv_pkg::t_cfg     cfg;
    pfcv_pkg::t_dp_cmd  dp_cmd;
    pfcv_pkg::t_dp_stat dp_stat;

    assign pready = 1'b1;

    pfcv_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_cfg     (cfg)
    );

    pfcv_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd),
        .o_in_stall (o_in_stall)
    );

    pfcv_dp #(
        .NUM_LOCKS  (NUM_LOCKS),
        .NUM_LEVELS (NUM_LEVELS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .i_in_data   (i_in_data),
        .i_cfg       (cfg),
        .i_out_stall (i_out_stall),
        .o_stat      (dp_stat),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

`ifndef SYNTH
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("beat accepted while previous beat in flight");

    a_floor_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.any_floor_active) |-> (o_out_data.floor_hz == '0))
        else $error("floor frequency without active floor lock");

    a_over_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status == pfcv_pkg::ST_OVER) |-> o_out_data.lock_active)
        else $error("over-locked status with inactive lock");

    a_inactive_codes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.status == pfcv_pkg::ST_NOT_CREATED
                      || o_out_data.status == pfcv_pkg::ST_UNDER
                      || o_out_data.status == pfcv_pkg::ST_NO_LOCK))
        |-> !o_out_data.lock_active)
        else $error("lock active with a status that implies inactive");
`endif

endmodule

`default_nettype wire
